/* hdl/srwa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srwa_pkg
// Shared constants and helpers for the sine-ripple warp address generator:
// register indexes, field widths, and the quarter-wave sine builder.
// ----------------------------------------------------------------------------
package srwa_pkg;

   // default sizes
   localparam int MAX_DIM_DEF         = 4096;
   localparam int SINE_INDEX_BITS_DEF = 10;

   // field widths fixed by the register map
   localparam int DIM_W      = 13;
   localparam int STEP_W     = 24;
   localparam int SCALE_W    = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int SINE_W     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PHASE_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_PHASE_STEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SHIFT_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SHIFT_SCALE  = 3'd5;

   // register reset values
   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 13'd1024;

   // pi/2 in unsigned Q61
   localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;

   // (a * b) >> 61 over the full 128-bit product
   function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[124:61];
   endfunction

   // round(32767 * sin(pi/2 * j / 2^qbits)), exact integer Taylor series;
   // evaluated only on constants, so it folds into a table at elaboration
   function automatic logic signed [SINE_W-1:0] quarter_sine(input int unsigned j,
                                                             input int unsigned qbits);
      logic [63:0] mask;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      logic        minus;
      mask  = (64'd1 << qbits) - 64'd1;
      x     = (HALF_PI_Q61 >> qbits) * 64'(j)
            + (((HALF_PI_Q61 & mask) * 64'(j)) >> qbits);
      x2    = mul_q61(x, x);
      term  = x;
      sum   = x;
      minus = 1'b1;
      for (int n = 3; n <= 27; n += 2) begin
         term = mul_q61(term, x2) / 64'((n - 1) * n);
         if (minus) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         minus = !minus;
      end
      r = mul_q61(sum, 64'd32767 << 40);
      r = (r + (64'd1 << 39)) >> 40;
      return r[SINE_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/srwa_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srwa_axis
// One warp axis: phase multiply, quarter-wave sine lookup, scale multiply,
// then add, floor and clamp. Four register stages, one transaction per cycle.
// ----------------------------------------------------------------------------
module srwa_axis #(
   parameter int MAX_DIM         = srwa_pkg::MAX_DIM_DEF,
   parameter int SINE_INDEX_BITS = srwa_pkg::SINE_INDEX_BITS_DEF,
   parameter bit COSINE          = 1'b0
) (
   input  wire logic                                  clock,
   input  wire logic [$clog2(MAX_DIM)-1:0]            coord,
   input  wire logic [$clog2(MAX_DIM)-1:0]            phase_coord,
   input  wire logic [srwa_pkg::STEP_W-1:0]           step,
   input  wire logic signed [srwa_pkg::SCALE_W-1:0]   scale,
   input  wire logic [srwa_pkg::DIM_W-1:0]            limit,
   output logic [$clog2(MAX_DIM)-1:0]                 result
);
   import srwa_pkg::*;

   localparam int CW      = $clog2(MAX_DIM);
   localparam int IB      = SINE_INDEX_BITS;
   localparam int QB      = SINE_INDEX_BITS - 2;
   localparam int QUARTER = 1 << QB;
   localparam int PW      = CW + STEP_W;
   localparam int MW      = SINE_W + SCALE_W;
   localparam int SHW     = MW - 15;
   localparam int AW      = ((CW + 8) > SHW ? (CW + 8) : SHW) + 1;
   localparam int LW      = (DIM_W > CW + 1) ? DIM_W : CW + 1;
   localparam logic [IB-1:0] IDX_OFFSET = COSINE ? IB'(QUARTER) : '0;

   // quarter-wave table, folded to constants
   logic signed [SINE_W-1:0] qtab [0:QUARTER];
   for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
      assign qtab[g] = quarter_sine(g, QB);
   end

   // clamp bound, refreshed every cycle from the register
   logic [LW-1:0] limit_ext;
   logic [CW-1:0] max_idx_in;
   logic [CW-1:0] max_idx_ff;

   assign limit_ext = LW'(limit);
   always_comb begin
      if (limit_ext == '0) begin
         max_idx_in = '0;
      end else if (limit_ext > LW'(MAX_DIM)) begin
         max_idx_in = CW'(MAX_DIM - 1);
      end else begin
         max_idx_in = CW'(limit_ext - LW'(1));
      end
   end

   // stage 1: phase product, table index
   logic [PW-1:0] phase_prod;
   logic [IB-1:0] idx_in;
   logic [IB-1:0] idx_ff;
   logic [CW-1:0] coord1_ff;

   assign phase_prod = PW'(phase_coord) * PW'(step);
   assign idx_in     = phase_prod[STEP_W-1 -: IB] + IDX_OFFSET;

   // stage 2: fold index into the quarter wave
   logic [1:0]               quad;
   logic [QB:0]              fold_idx;
   logic signed [SINE_W-1:0] qval;
   logic signed [SINE_W-1:0] tval_in;
   logic signed [SINE_W-1:0] tval_ff;
   logic [CW-1:0]            coord2_ff;

   assign quad     = idx_ff[IB-1 -: 2];
   assign fold_idx = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, idx_ff[QB-1:0]})
                             : {1'b0, idx_ff[QB-1:0]};
   assign qval     = qtab[fold_idx];
   assign tval_in  = quad[1] ? -qval : qval;

   // stage 3: scale product
   logic signed [MW-1:0] prod_in;
   logic signed [MW-1:0] prod_ff;
   logic [CW-1:0]        coord3_ff;

   assign prod_in = MW'(tval_ff) * MW'(scale);

   // stage 4: floor shift, add, clamp
   logic signed [SHW-1:0]  shift_q8;
   logic signed [AW-1:0]   pos_q8;
   logic signed [AW-9:0]   pos;
   logic [CW-1:0]          result_in;
   logic [CW-1:0]          result_ff;

   assign shift_q8 = prod_ff[MW-1:15];
   assign pos_q8   = $signed({{(AW-CW-8){1'b0}}, coord3_ff, 8'd0}) + AW'(shift_q8);
   assign pos      = pos_q8[AW-1:8];

   always_comb begin
      if (pos < 0) begin
         result_in = '0;
      end else if (pos > $signed({{(AW-8-CW){1'b0}}, max_idx_ff})) begin
         result_in = max_idx_ff;
      end else begin
         result_in = pos[CW-1:0];
      end
   end

   // advance all stages every cycle
   always_ff @(posedge clock) begin
      max_idx_ff <= max_idx_in;
      idx_ff     <= idx_in;
      coord1_ff  <= coord;
      tval_ff    <= tval_in;
      coord2_ff  <= coord1_ff;
      prod_ff    <= prod_in;
      coord3_ff  <= coord2_ff;
      result_ff  <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

/* hdl/sine_ripple_warp_address_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Output: rsp_valid rises with the result from the last register stage;
//   rsp_source_x and rsp_source_y are to be taken while it is high.
// Throughput: one transaction per cycle; busy stays low, set by the
//   four-stage pipeline (phase multiply, sine lookup, scale multiply, clamp).
// Results appear once on the rsp_ ports; the receiver cannot stall.
// Reset clears the valid pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
// sine_ripple_warp_address_top
// Ripple-warp source address generator: x moves by a sine of the row phase,
// y by a cosine of the column phase, both clamped to the image.
// ----------------------------------------------------------------------------
module sine_ripple_warp_address_top #(
   parameter int MAX_DIM         = srwa_pkg::MAX_DIM_DEF,
   parameter int SINE_INDEX_BITS = srwa_pkg::SINE_INDEX_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [$clog2(MAX_DIM)-1:0]         req_dest_x,
   input  wire logic [$clog2(MAX_DIM)-1:0]         req_dest_y,
   output logic                                    rsp_valid,
   output logic [$clog2(MAX_DIM)-1:0]              rsp_source_x,
   output logic [$clog2(MAX_DIM)-1:0]              rsp_source_y,
   input  wire logic                               csr_write_en,
   input  wire logic [srwa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srwa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import srwa_pkg::*;

   localparam int STAGES = 4;

   // configuration registers
   logic [DIM_W-1:0]          image_width_ff;
   logic [DIM_W-1:0]          image_height_ff;
   logic [STEP_W-1:0]         row_phase_step_ff;
   logic [STEP_W-1:0]         col_phase_step_ff;
   logic signed [SCALE_W-1:0] x_shift_scale_ff;
   logic signed [SCALE_W-1:0] y_shift_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= IMAGE_DIM_RESET;
         image_height_ff   <= IMAGE_DIM_RESET;
         row_phase_step_ff <= '0;
         col_phase_step_ff <= '0;
         x_shift_scale_ff  <= '0;
         y_shift_scale_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_ROW_PHASE_STEP: begin
               row_phase_step_ff <= csr_wdata[STEP_W-1:0];
            end
            CSR_COL_PHASE_STEP: begin
               col_phase_step_ff <= csr_wdata[STEP_W-1:0];
            end
            CSR_X_SHIFT_SCALE: begin
               x_shift_scale_ff <= $signed(csr_wdata[SCALE_W-1:0]);
            end
            CSR_Y_SHIFT_SCALE: begin
               y_shift_scale_ff <= $signed(csr_wdata[SCALE_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // always ready: a transaction may enter every cycle
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // carry valid alongside the datapath stages
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_ff;

   assign valid_in = {valid_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // x: sine of the row phase
   srwa_axis #(
      .MAX_DIM         (MAX_DIM),
      .SINE_INDEX_BITS (SINE_INDEX_BITS),
      .COSINE          (1'b0)
   ) u_axis_x (
      .clock       (clock),
      .coord       (req_dest_x),
      .phase_coord (req_dest_y),
      .step        (row_phase_step_ff),
      .scale       (x_shift_scale_ff),
      .limit       (image_width_ff),
      .result      (rsp_source_x)
   );

   // y: cosine of the column phase
   srwa_axis #(
      .MAX_DIM         (MAX_DIM),
      .SINE_INDEX_BITS (SINE_INDEX_BITS),
      .COSINE          (1'b1)
   ) u_axis_y (
      .clock       (clock),
      .coord       (req_dest_y),
      .phase_coord (req_dest_x),
      .step        (col_phase_step_ff),
      .scale       (y_shift_scale_ff),
      .limit       (image_height_ff),
      .result      (rsp_source_y)
   );

   assign rsp_valid = valid_ff[STAGES-1];

endmodule
`default_nettype wire
